// File: design/ring_buffer_deque_defines.svh
// Assertion macros for the deque design.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RING_BUFFER_DEQUE_DEFINES_SVH
`define RING_BUFFER_DEQUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property at each rising clock edge outside of reset.
`define RBD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("deque assertion failed");

// Check that a condition never holds outside of reset.
`define RBD_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("deque forbidden condition seen");

`else

`define RBD_ASSERT(label, clk, rst_n, prop)
`define RBD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: design/rbd_pkg.sv
package rbd_pkg;

	localparam int DATA_W   = 32;
	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_BACK  = 2'd2,
		OP_POP_BACK   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Per-beat decision from the pointer engine to the store and result stage
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} step_t;

endpackage

// File: design/rbd_channels.sv
interface rbd_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [rbd_pkg::OPCODE_W-1:0]       opcode;
	logic signed [rbd_pkg::DATA_W-1:0]  push_value;

	modport source (output valid, output opcode, output push_value, input ready);
	modport sink (input valid, input opcode, input push_value, output ready);
endinterface

interface rbd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [rbd_pkg::DATA_W-1:0]  pop_value;
	logic [rbd_pkg::STATUS_W-1:0]       status;

	modport source (output valid, output pop_value, output status, input ready);
	modport sink (input valid, input pop_value, input status, output ready);
endinterface

// File: design/ring_buffer_deque.sv
// Double-ended queue of 32-bit signed words in a circular store of DEPTH entries.
// Command channel (cmd): opcode selects push front, pop front, push back or pop
// back; push_value is the word stored by a push and ignored by a pop.
// Response channel (rsp): exactly one beat per command, in command order.
// pop_value carries the popped word, -1 on a pop from an empty deque and 0 on
// any push; status is ok, empty (pop with nothing held) or full (push dropped).
// Latency: the response is valid in the cycle after the command is accepted.
// Throughput: one command per cycle while rsp is not stalled; each command
// makes at most one access to the store RAM (one write port, one registered
// read port); the next command's pointer update is ready by the next clock edge.
// Stall: while rsp is valid and rsp.ready is low, cmd.ready is low and the
// pending response holds; cmd.ready rises again as soon as rsp is taken.
// Reset: arst_n clears the occupancy to zero, sets both ends to the middle of
// the store and drops any pending response; store contents are not cleared and
// need no clearing pass, since a pop only reads entries that a push wrote.
module ring_buffer_deque #(
	parameter int DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	rbd_cmd_if.sink  cmd,
	rbd_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);

	rbd_pkg::step_t                  step;
	logic [AW-1:0]                   addr;
	logic                            fire;
	logic [rbd_pkg::DATA_W-1:0]      rd_data;
	logic                            valid_s1;
	rbd_pkg::status_t                status_s1;
	logic                            from_ram_s1;

	// Take a command when the response stage is free or being drained
	assign cmd.ready = !valid_s1 || rsp.ready;
	assign fire      = cmd.valid && cmd.ready;

	rbd_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.op    (rbd_pkg::opcode_t'(cmd.opcode)),
		.step  (step),
		.addr  (addr)
	);

	rbd_ram #(
		.WIDTH(rbd_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (step.wr_en),
		.wr_addr(addr),
		.wr_data(cmd.push_value),
		.rd_en  (step.rd_en),
		.rd_addr(addr),
		.rd_data(rd_data)
	);

	// Hold the response beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_s1   <= step.status;
			from_ram_s1 <= step.rd_en;
		end
	end

	// Popped word comes straight from the RAM read register
	assign rsp.valid     = valid_s1;
	assign rsp.status    = status_s1;
	assign rsp.pop_value = from_ram_s1 ? rd_data
		: ((status_s1 == rbd_pkg::ST_EMPTY) ? '1 : '0);

	`RBD_ASSERT(a_rsp_holds, clk, arst_n, valid_s1 && !rsp.ready |=> valid_s1 && $stable(status_s1))
	`RBD_ASSERT_NEVER(a_ram_beat_ok, clk, arst_n, valid_s1 && from_ram_s1 && status_s1 != rbd_pkg::ST_OK)

endmodule

// File: design/rbd_ram.sv
module rbd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register read data; read data holds when not enabled
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: design/rbd_ctrl.sv
`include "ring_buffer_deque_defines.svh"

module rbd_ctrl #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  rbd_pkg::opcode_t op,
	output rbd_pkg::step_t   step,
	output logic [AW-1:0]    addr
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [AW-1:0] MID  = AW'(DEPTH / 2);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [AW-1:0] front_prev, front_next, back_prev, back_next;
	logic [CW-1:0] count_q, count_d;
	logic          full, empty;

	// Wrap the indexes at both ends of the store
	assign front_prev = (front_q == '0)   ? LAST : front_q - AW'(1);
	assign front_next = (front_q == LAST) ? '0   : front_q + AW'(1);
	assign back_prev  = (back_q == '0)    ? LAST : back_q - AW'(1);
	assign back_next  = (back_q == LAST)  ? '0   : back_q + AW'(1);

	assign full  = (count_q == FULL_COUNT);
	assign empty = (count_q == '0);

	// Decide store access, status and next pointers for the current beat
	always_comb begin
		step.wr_en  = 1'b0;
		step.rd_en  = 1'b0;
		step.status = rbd_pkg::ST_OK;
		addr        = front_q;
		front_d     = front_q;
		back_d      = back_q;
		count_d     = count_q;
		unique case (op)
			rbd_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					step.status = rbd_pkg::ST_FULL;
				end else begin
					step.wr_en = fire;
					addr       = front_prev;
					front_d    = front_prev;
					count_d    = count_q + CW'(1);
				end
			end
			rbd_pkg::OP_POP_FRONT: begin
				if (empty) begin
					step.status = rbd_pkg::ST_EMPTY;
				end else begin
					step.rd_en = fire;
					addr       = front_q;
					front_d    = front_next;
					count_d    = count_q - CW'(1);
				end
			end
			rbd_pkg::OP_PUSH_BACK: begin
				if (full) begin
					step.status = rbd_pkg::ST_FULL;
				end else begin
					step.wr_en = fire;
					addr       = back_q;
					back_d     = back_next;
					count_d    = count_q + CW'(1);
				end
			end
			rbd_pkg::OP_POP_BACK: begin
				if (empty) begin
					step.status = rbd_pkg::ST_EMPTY;
				end else begin
					step.rd_en = fire;
					addr       = back_prev;
					back_d     = back_prev;
					count_d    = count_q - CW'(1);
				end
			end
			default: begin
				step.status = rbd_pkg::ST_OK;
			end
		endcase
	end

	// Advance pointers and occupancy on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= MID;
			back_q  <= MID;
			count_q <= '0;
		end else if (fire) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	`RBD_ASSERT_NEVER(a_no_rd_and_wr, clk, arst_n, step.wr_en && step.rd_en)
	`RBD_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_COUNT)
	`RBD_ASSERT(a_push_grows, clk, arst_n, step.wr_en |=> count_q == $past(count_q) + CW'(1))

endmodule
